FILE: rtl/fqrk_pkg.sv
// ----------------------------------------------------------------------------
// fqrk_pkg
// Types and constants shared by the keyed removal queue modules.
// ----------------------------------------------------------------------------
package fqrk_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_WIDTH   = 16;
  localparam int DATA_WIDTH  = 32;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [KEY_WIDTH-1:0]  key_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic {
    REQ_APPEND = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SCAN,
    ST_SHIFT
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] entry_id;
    logic [31:0] entry_payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_payload;
    logic [4:0]  entry_count;
    logic        queue_empty;
  } out_item_t;

  // Command from the sequencer to the slot memory.
  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  wr_en;
    idx_t  wr_addr;
    key_t  wr_key;
    data_t wr_data;
  } mem_cmd_t;

  // Registered read data from the slot memory.
  typedef struct packed {
    key_t  key;
    data_t data;
  } mem_rsp_t;

endpackage

FILE: rtl/fifo_queue_remove_by_key_top.sv
// ----------------------------------------------------------------------------
// fifo_queue_remove_by_key_top
// Ordered queue of keyed entries with append at the tail and removal by key.
// ----------------------------------------------------------------------------
// An append writes the tail slot and registers its result in the append state; a
// remove makes one pass of the single read port, which compares entries up to
// the match and then moves the later ones up.
// Throughput: one request at a time; busy drops on the edge that sets the result.
// Reset: synchronous active-low rst_n empties the queue; slot contents are
// left as they are. The result strobe cannot be stalled by the receiver.
module fifo_queue_remove_by_key_top
  import fqrk_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  mem_cmd_t cmd;
  mem_rsp_t rsp;

  fqrk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .rsp       (rsp)
  );

  fqrk_store u_store (
    .clk (clk),
    .cmd (cmd),
    .rsp (rsp)
  );

endmodule

FILE: rtl/fqrk_store.sv
// ----------------------------------------------------------------------------
// fqrk_store
// Slot memory for keys and data words: one write port, one registered read.
// ----------------------------------------------------------------------------
module fqrk_store
  import fqrk_pkg::*;
(
  input  logic     clk,
  input  mem_cmd_t cmd,
  output mem_rsp_t rsp
);

  mem_rsp_t slots [QUEUE_DEPTH];
  mem_rsp_t rd_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      slots[cmd.wr_addr] <= '{key: cmd.wr_key, data: cmd.wr_data};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_r <= slots[cmd.rd_addr];
    end
  end

  assign rsp = rd_r;

endmodule

FILE: rtl/fqrk_ctrl.sv
// ----------------------------------------------------------------------------
// fqrk_ctrl
// Sequencer: appends at the tail, scans for a key and closes the gap.
// ----------------------------------------------------------------------------
module fqrk_ctrl
  import fqrk_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  output mem_cmd_t  cmd,
  input  mem_rsp_t  rsp
);

  state_t  state_r, state_nxt;
  cnt_t    fill_r, fill_nxt;
  cnt_t    rd_idx_r, rd_idx_nxt;
  logic    pend_r, pend_nxt;
  idx_t    pidx_r, pidx_nxt;
  key_t    key_r, key_nxt;
  data_t   data_r, data_nxt;
  data_t   found_r, found_nxt;
  logic    vld_r, vld_nxt;
  out_item_t res_r, res_nxt;

  logic accept;
  logic full;
  logic match;
  logic drained;
  logic rd_more;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign full    = (fill_r >= DEPTH_CNT);
  assign match   = pend_r && (rsp.key == key_r);
  assign rd_more = (rd_idx_r < fill_r);
  assign drained = !pend_r && !rd_more;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_item.req_type == REQ_REMOVE) ? ST_SCAN : ST_APPEND;
        end
      end
      ST_APPEND: state_nxt = ST_IDLE;
      ST_SCAN: begin
        if (match) begin
          state_nxt = ST_SHIFT;
        end else if (drained) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (drained) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory command and result.
  always_comb begin
    fill_nxt   = fill_r;
    rd_idx_nxt = rd_idx_r;
    pend_nxt   = 1'b0;
    pidx_nxt   = pidx_r;
    key_nxt    = key_r;
    data_nxt   = data_r;
    found_nxt  = found_r;
    vld_nxt    = 1'b0;
    res_nxt    = res_r;
    cmd        = '0;
    cmd.rd_addr = rd_idx_r[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt    = KEY_WIDTH'(in_item.entry_id);
          data_nxt   = DATA_WIDTH'(in_item.entry_payload);
          rd_idx_nxt = '0;
        end
      end
      ST_APPEND: begin
        vld_nxt               = 1'b1;
        res_nxt.found_payload = '0;
        if (full) begin
          res_nxt.status      = STAT_FULL;
          res_nxt.entry_count = 5'(fill_r);
          res_nxt.queue_empty = (fill_r == '0);
        end else begin
          cmd.wr_en           = 1'b1;
          cmd.wr_addr         = fill_r[IDX_W-1:0];
          cmd.wr_key          = key_r;
          cmd.wr_data         = data_r;
          fill_nxt            = fill_r + cnt_t'(1);
          res_nxt.status      = STAT_DONE;
          res_nxt.entry_count = 5'(fill_r + cnt_t'(1));
          res_nxt.queue_empty = 1'b0;
        end
      end
      ST_SCAN: begin
        // Reads are issued every cycle; each compare uses the registered read data in the next cycle.
        if (match) begin
          found_nxt  = rsp.data;
          rd_idx_nxt = cnt_t'(pidx_r) + cnt_t'(1);
        end else if (drained) begin
          vld_nxt               = 1'b1;
          res_nxt.status        = STAT_MISS;
          res_nxt.found_payload = '0;
          res_nxt.entry_count   = 5'(fill_r);
          res_nxt.queue_empty   = (fill_r == '0);
        end else if (rd_more) begin
          cmd.rd_en  = 1'b1;
          pend_nxt   = 1'b1;
          pidx_nxt   = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt = rd_idx_r + cnt_t'(1);
        end
      end
      ST_SHIFT: begin
        // Each entry behind the removed one moves one slot toward the front.
        if (rd_more) begin
          cmd.rd_en  = 1'b1;
          pend_nxt   = 1'b1;
          pidx_nxt   = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt = rd_idx_r + cnt_t'(1);
        end
        if (pend_r) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = pidx_r - idx_t'(1);
          cmd.wr_key  = rsp.key;
          cmd.wr_data = rsp.data;
        end
        if (drained) begin
          vld_nxt               = 1'b1;
          fill_nxt              = fill_r - cnt_t'(1);
          res_nxt.status        = STAT_DONE;
          res_nxt.found_payload = 32'(found_r);
          res_nxt.entry_count   = 5'(fill_r - cnt_t'(1));
          res_nxt.queue_empty   = (fill_r == cnt_t'(1));
        end
      end
      default: begin
        vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      pend_r  <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    pidx_r   <= pidx_nxt;
    key_r    <= key_nxt;
    data_r   <= data_nxt;
    found_r  <= found_nxt;
    res_r    <= res_nxt;
  end

  assign out_valid = vld_r;
  assign out_item  = res_r;

endmodule
